/* rtl/core/markov_transition_counter_unit_macros.svh */
// Assertion macros for the Markov transition counter checker
`ifndef MARKOV_TRANSITION_COUNTER_UNIT_MACROS_SVH
`define MARKOV_TRANSITION_COUNTER_UNIT_MACROS_SVH

// Checked only while out of reset
`define MTC_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checked at every edge, reset included
`define MTC_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/mtc_pkg.sv */
// Shared constants, types and helpers of the Markov transition counter
package mtc_pkg;

    localparam int MaxStates   = 16;
    localparam int MaxEntities = 1024;
    localparam int CountBits   = 32;

    localparam int StBits   = $clog2(MaxStates);
    localparam int EntBits  = $clog2(MaxEntities);
    localparam int CellBits = 2 * StBits;
    localparam int NBits    = StBits + 1;
    localparam int WgtBits  = CountBits + 9;
    localparam int SumBits  = WgtBits + StBits + 1;
    localparam int RemBits  = SumBits + 1;
    localparam int ProbBits = 16;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_NUM_STATES = 2'd0;
    localparam t_cfg_idx CFG_ALPHA      = 2'd1;
    localparam t_cfg_idx CFG_DEAD_UNI   = 2'd2;

    typedef enum logic [9:0] {
        ST_CLEAR   = 10'b00_0000_0001,
        ST_IDLE    = 10'b00_0000_0010,
        ST_OBS_ENT = 10'b00_0000_0100,
        ST_OBS_CNT = 10'b00_0000_1000,
        ST_SUM_RD  = 10'b00_0001_0000,
        ST_SUM_ACC = 10'b00_0010_0000,
        ST_COL_RD  = 10'b00_0100_0000,
        ST_COL_LD  = 10'b00_1000_0000,
        ST_DIV     = 10'b01_0000_0000,
        ST_OUT     = 10'b10_0000_0000
    } t_state;

    // floor(65536 / n) held at 65535
    function automatic logic [ProbBits-1:0] uniform_prob(input logic [NBits-1:0] n);
        logic [ProbBits-1:0] p;
        unique case (n)
            5'd1:    p = 16'hFFFF;
            5'd2:    p = 16'd32768;
            5'd3:    p = 16'd21845;
            5'd4:    p = 16'd16384;
            5'd5:    p = 16'd13107;
            5'd6:    p = 16'd10922;
            5'd7:    p = 16'd9362;
            5'd8:    p = 16'd8192;
            5'd9:    p = 16'd7281;
            5'd10:   p = 16'd6553;
            5'd11:   p = 16'd5957;
            5'd12:   p = 16'd5461;
            5'd13:   p = 16'd5041;
            5'd14:   p = 16'd4681;
            5'd15:   p = 16'd4369;
            5'd16:   p = 16'd4096;
            default: p = 16'd0;
        endcase
        return p;
    endfunction

endpackage

/* rtl/core/markov_transition_counter_unit.sv */
// Markov transition counter: per-entity last state, count table, smoothed row read-out
// An observation reads the entity table and, when the entity has a last state, bumps a
// count; both go through single-port reads of the entity and count memories.
// A row read of n columns first sums the row through the count memory, then per column
// reads and loads the cell, runs 16 steps of the shared restoring divider (skipped for a
// zero-sum row or a full-weight cell) and presents the result in the output state, held
// while the sink stalls. After reset a clearing pass over all 1024 entries empties the
// entity table; the input is not ready until it ends, and is not ready while any item is in work.
module markov_transition_counter_unit import mtc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // entity[9:0], state_id[13:10], row_index[17:14]
    input  logic        s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // column_index[3:0], raw_count[35:4], probability[51:36]
    output logic        m_axis_tlast
);

    t_state r_state, n_state;

    logic [4:0]          r_num_states;
    logic [15:0]         r_alpha;
    logic                r_dead_uni;

    logic [EntBits:0]    ent_mem [MaxEntities];
    logic [EntBits:0]    r_ent_q;
    logic [EntBits-1:0]  r_clr_addr;
    logic [EntBits-1:0]  r_ent;
    logic [StBits-1:0]   r_obs_st;

    logic [CountBits-1:0] cnt_mem [MaxStates*MaxStates];
    logic [MaxStates*MaxStates-1:0] r_cnt_vld;
    logic [CountBits-1:0] r_cnt_q;
    logic                 r_cnt_qv;
    logic [CellBits-1:0]  cnt_raddr;
    logic [CellBits-1:0]  r_cnt_waddr;

    logic [StBits-1:0]   r_row;
    logic [StBits-1:0]   r_col;
    logic [SumBits-1:0]  r_sum;
    logic [RemBits-1:0]  r_rem;
    logic [3:0]          r_step;
    logic [ProbBits-1:0] r_prob;
    logic [CountBits-1:0] r_raw;

    logic [NBits-1:0]    n_use;
    logic [CountBits-1:0] cnt_cur;
    logic [WgtBits-1:0]  weight;
    logic [RemBits-1:0]  rem_sh;
    logic                col_end;
    logic                in_acc;
    logic [EntBits-1:0]  in_ent;
    logic [StBits-1:0]   in_st;
    logic [StBits-1:0]   in_row;

    assign in_ent = s_axis_tdata[EntBits-1:0];
    assign in_st  = s_axis_tdata[EntBits+StBits-1:EntBits];
    assign in_row = s_axis_tdata[EntBits+2*StBits-1:EntBits+StBits];

    always_comb begin
        if (r_num_states == 5'd0) begin
            n_use = NBits'(1);
        end else if (r_num_states > 5'(MaxStates)) begin
            n_use = NBits'(MaxStates);
        end else begin
            n_use = r_num_states;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cnt_cur       = r_cnt_qv ? r_cnt_q : '0;
    assign weight        = {1'b0, cnt_cur, 8'b0} + WgtBits'(r_alpha);
    assign rem_sh        = {r_rem[RemBits-2:0], 1'b0};
    assign col_end       = ({1'b0, r_col} == n_use - NBits'(1));

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states <= 5'd16;
            r_alpha      <= '0;
            r_dead_uni   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_STATES: r_num_states <= i_cfg_data[4:0];
                CFG_ALPHA:      r_alpha      <= i_cfg_data;
                CFG_DEAD_UNI:   r_dead_uni   <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Entity table: one read and one write port, cleared by a sweep after reset
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            ent_mem[r_clr_addr] <= '0;
        end else if (r_state == ST_OBS_ENT) begin
            ent_mem[r_ent] <= {1'b1, EntBits'(r_obs_st)};
        end
        r_ent_q <= ent_mem[in_ent];
    end

    // Count table: registered read, entries without a valid bit read as zero
    always_comb begin
        if (r_state == ST_OBS_ENT) begin
            cnt_raddr = {r_ent_q[StBits-1:0], r_obs_st};
        end else begin
            cnt_raddr = {r_row, r_col};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OBS_CNT && cnt_cur != '1) begin
            cnt_mem[r_cnt_waddr] <= cnt_cur + CountBits'(1);
        end
        r_cnt_q  <= cnt_mem[cnt_raddr];
        r_cnt_qv <= r_cnt_vld[cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
        end else if (r_state == ST_OBS_CNT) begin
            r_cnt_vld[r_cnt_waddr] <= 1'b1;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:   if (r_clr_addr == '1) n_state = ST_IDLE;
            ST_IDLE: begin
                if (in_acc) begin
                    if (!s_axis_tuser) begin
                        if ({1'b0, in_st} < n_use) n_state = ST_OBS_ENT;
                    end else if ({1'b0, in_row} < n_use) begin
                        n_state = ST_SUM_RD;
                    end
                end
            end
            ST_OBS_ENT: n_state = r_ent_q[EntBits] ? ST_OBS_CNT : ST_IDLE;
            ST_OBS_CNT: n_state = ST_IDLE;
            ST_SUM_RD:  n_state = ST_SUM_ACC;
            ST_SUM_ACC: n_state = col_end ? ST_COL_RD : ST_SUM_RD;
            ST_COL_RD:  n_state = ST_COL_LD;
            ST_COL_LD: begin
                if (r_sum == '0 || SumBits'(weight) >= r_sum) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV:     if (r_step == 4'd15) n_state = ST_OUT;
            ST_OUT: begin
                if (m_axis_tready) n_state = col_end ? ST_IDLE : ST_COL_RD;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_col      <= '0;
            r_step     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + EntBits'(1);
            priority if (r_state == ST_IDLE) begin
                r_col <= '0;
            end else if (r_state == ST_SUM_ACC) begin
                r_col <= col_end ? '0 : r_col + StBits'(1);
            end else if (r_state == ST_OUT && m_axis_tready) begin
                r_col <= r_col + StBits'(1);
            end
            if (r_state == ST_DIV) begin
                r_step <= r_step + 4'd1;
            end else begin
                r_step <= '0;
            end
        end
    end

    // Payload and datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ent    <= in_ent;
            r_obs_st <= in_st;
            r_row    <= in_row;
            r_sum    <= '0;
        end
        if (r_state == ST_OBS_ENT) r_cnt_waddr <= cnt_raddr;
        if (r_state == ST_SUM_ACC) r_sum <= r_sum + SumBits'(weight);
        if (r_state == ST_COL_LD) begin
            r_raw  <= cnt_cur;
            r_rem  <= RemBits'(weight);
            priority if (r_sum == '0) begin
                r_prob <= r_dead_uni ? uniform_prob(n_use) : '0;
            end else if (SumBits'(weight) >= r_sum) begin
                r_prob <= '1;
            end else begin
                r_prob <= '0;
            end
        end
        // one restoring step per cycle
        if (r_state == ST_DIV) begin
            if (rem_sh >= RemBits'(r_sum)) begin
                r_rem  <= rem_sh - RemBits'(r_sum);
                r_prob <= {r_prob[ProbBits-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_prob <= {r_prob[ProbBits-2:0], 1'b0};
            end
        end
    end

    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tlast  = col_end;
    assign m_axis_tdata  = {4'b0, r_prob, r_raw, r_col};

endmodule

/* rtl/core/mtc_checker.sv */
// Port-level checker for the Markov transition counter, bound to the top level
`include "markov_transition_counter_unit_macros.svh"

module mtc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    `MTC_ASSERT_ALWAYS(a_rst_not_ready, i_clk, !i_rst_n, ##1 !s_axis_tready, "ready right after reset")
    `MTC_ASSERT(a_one_side, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "input ready while result pending")
    `MTC_ASSERT(a_hold_out, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, ##1 (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "stalled result changed")

endmodule

bind markov_transition_counter_unit mtc_checker u_mtc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
